/* hw/rtl/adrc_pkg.sv */
package adrc_pkg;

  // configuration port geometry: 64-bit data, registers on 8-byte steps
  localparam int CFG_FIELD_W = 4;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_BITS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_BITS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BITS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PERIOD = 2'd3;

  typedef struct packed {
    logic [CFG_FIELD_W-1:0] row_w;
    logic [CFG_FIELD_W-1:0] col_w;
    logic [CFG_FIELD_W-1:0] dat_w;
  } cfg_t;

endpackage

/* hw/rtl/async_dram_with_refresh_check.sv */
// channel   | handshake                      | payload
// ----------+--------------------------------+-----------------------------------------
// input     | start & !busy                  | in_ras/cas/we/oe_active, in_addr_bus,
//           |                                | in_data_bus, in_now_time
// result    | out_strobe, one cycle          | out_read_data, out_read_valid,
//           |                                | out_drive_enable, out_refresh_error
// config    | psel & penable & pwrite        | paddr (8 bytes per register), pwdata
//
// for each request the accept edge issues the refresh-time and word memory
// reads, the next edge compares the refresh time, writes it back and loads the result
// registers; busy is high for that one cycle and out_strobe follows in the next cycle
// reset (rst_n low, synchronous) clears control state and the per-row valid bits of the
// refresh-time memory; word contents are not cleared
// the receiver cannot stall: each result shows for exactly one cycle
module async_dram_with_refresh_check #(
  parameter int MAX_ROW_BITS = 8,
  parameter int MAX_COL_BITS = 8,
  parameter int DATA_WIDTH   = 8,
  parameter int TIME_WIDTH   = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_ras_active,
  input  logic                              in_cas_active,
  input  logic                              in_we_active,
  input  logic                              in_oe_active,
  input  logic [((MAX_ROW_BITS > MAX_COL_BITS) ? MAX_ROW_BITS : MAX_COL_BITS)-1:0] in_addr_bus,
  input  logic [DATA_WIDTH-1:0]             in_data_bus,
  input  logic [TIME_WIDTH-1:0]             in_now_time,
  output logic                              out_strobe,
  output logic [DATA_WIDTH-1:0]             out_read_data,
  output logic                              out_read_valid,
  output logic                              out_drive_enable,
  output logic                              out_refresh_error,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [adrc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [adrc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [adrc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int WORD_ADDR_W = MAX_ROW_BITS + MAX_COL_BITS;
  // wide enough to hold any width up to DATA_WIDTH
  localparam int SW          = 6;

  typedef enum logic {ST_IDLE, ST_WORK} state_t;

  adrc_pkg::cfg_t          cfg;
  logic [TIME_WIDTH-1:0]   refresh_period;

  state_t                  state_r;
  logic                    strobe_r;
  logic                    read_valid_r;
  logic                    drive_r;

  logic                    ras_prev_r;
  logic                    cas_prev_r;
  logic [MAX_ROW_BITS-1:0] row_latch_r;
  logic [MAX_ROW_BITS-1:0] row_latch_nxt;
  logic [MAX_ROW_BITS-1:0] counter_r;
  logic [MAX_ROW_BITS-1:0] counter_nxt;
  logic                    error_r;
  logic [DATA_WIDTH-1:0]   read_hold_r;
  logic                    rd_pend_r;
  logic                    drive_pend_r;

  logic                    acc;
  logic [SW-1:0]           rb;
  logic [SW-1:0]           cb;
  logic [SW-1:0]           db;
  logic [MAX_ROW_BITS-1:0] rmask;
  logic [MAX_COL_BITS-1:0] cmask;
  logic [DATA_WIDTH-1:0]   dmask;
  logic                    ras_fall;
  logic                    cas_fall;
  logic [MAX_ROW_BITS-1:0] addr_row;
  logic [MAX_ROW_BITS-1:0] ref_row;
  logic [MAX_ROW_BITS-1:0] acc_row;
  logic [MAX_COL_BITS-1:0] col;
  logic [WORD_ADDR_W-1:0]  word_addr;
  logic                    word_we;
  logic                    word_re;
  logic [DATA_WIDTH-1:0]   word_rdata;
  logic                    late;
  logic                    drive;

  adrc_cfg_regs #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .cfg            (cfg),
    .refresh_period (refresh_period)
  );

  // zero or out of range means the full width
  assign rb = (cfg.row_w == '0 || SW'(cfg.row_w) > SW'(MAX_ROW_BITS)) ?
              SW'(MAX_ROW_BITS) : SW'(cfg.row_w);
  assign cb = (cfg.col_w == '0 || SW'(cfg.col_w) > SW'(MAX_COL_BITS)) ?
              SW'(MAX_COL_BITS) : SW'(cfg.col_w);
  assign db = (cfg.dat_w == '0 || SW'(cfg.dat_w) > SW'(DATA_WIDTH)) ?
              SW'(DATA_WIDTH) : SW'(cfg.dat_w);

  assign rmask = ~({MAX_ROW_BITS{1'b1}} << rb);
  assign cmask = ~({MAX_COL_BITS{1'b1}} << cb);
  assign dmask = ~({DATA_WIDTH{1'b1}} << db);

  assign busy     = (state_r == ST_WORK);
  assign acc      = start & ~busy;
  assign ras_fall = in_ras_active & ~ras_prev_r;
  assign cas_fall = in_cas_active & ~cas_prev_r & in_ras_active;
  assign drive    = in_oe_active & in_cas_active & ~in_we_active;

  assign addr_row = in_addr_bus[MAX_ROW_BITS-1:0] & rmask;
  assign col      = in_addr_bus[MAX_COL_BITS-1:0] & cmask;

  always_comb begin
    row_latch_nxt = row_latch_r;
    counter_nxt   = counter_r;
    ref_row       = addr_row;
    if (ras_fall) begin
      if (!cas_prev_r) begin
        row_latch_nxt = addr_row;
      end else begin
        // cas-before-ras: refresh the counter's row
        ref_row     = counter_r & rmask;
        counter_nxt = (ref_row + 1'b1) & rmask;
      end
    end
  end

  // both strobes falling together: the access uses the row just latched
  assign acc_row   = row_latch_nxt & rmask;
  assign word_addr = (WORD_ADDR_W'(acc_row) << cb) | WORD_ADDR_W'(col);
  assign word_we   = acc & cas_fall & in_we_active;
  assign word_re   = acc & cas_fall & ~in_we_active;

  adrc_refresh_mem #(
    .ROW_W  (MAX_ROW_BITS),
    .TIME_W (TIME_WIDTH)
  ) u_refresh (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (acc & ras_fall),
    .rd_row (ref_row),
    .rd_now (in_now_time),
    .period (refresh_period),
    .late   (late)
  );

  adrc_word_mem #(
    .ADDR_W (WORD_ADDR_W),
    .DATA_W (DATA_WIDTH)
  ) u_word (
    .clk   (clk),
    .we    (word_we),
    .re    (word_re),
    .addr  (word_addr),
    .wdata (in_data_bus & dmask),
    .rdata (word_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      strobe_r     <= 1'b0;
      read_valid_r <= 1'b0;
      drive_r      <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          strobe_r <= 1'b0;
          if (acc) begin
            state_r <= ST_WORK;
          end
        end
        ST_WORK: begin
          state_r      <= ST_IDLE;
          strobe_r     <= 1'b1;
          read_valid_r <= rd_pend_r;
          drive_r      <= drive_pend_r;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ras_prev_r   <= 1'b0;
      cas_prev_r   <= 1'b0;
      row_latch_r  <= '0;
      counter_r    <= '0;
      error_r      <= 1'b0;
      read_hold_r  <= '0;
      rd_pend_r    <= 1'b0;
      drive_pend_r <= 1'b0;
    end else if (acc) begin
      ras_prev_r   <= in_ras_active;
      cas_prev_r   <= in_cas_active;
      row_latch_r  <= row_latch_nxt;
      counter_r    <= counter_nxt;
      rd_pend_r    <= word_re;
      drive_pend_r <= drive;
    end else if (busy) begin
      error_r <= error_r | late;
      if (rd_pend_r) begin
        read_hold_r <= word_rdata;
      end
    end
  end

  assign out_strobe        = strobe_r;
  assign out_read_data     = read_hold_r;
  assign out_read_valid    = read_valid_r;
  assign out_drive_enable  = drive_r;
  assign out_refresh_error = error_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a request in work");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_refresh_error |=> out_refresh_error)
    else $error("refresh error flag cleared");

endmodule

/* hw/rtl/adrc_cfg_regs.sv */
module adrc_cfg_regs #(
  parameter int TIME_WIDTH = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [adrc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [adrc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [adrc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output adrc_pkg::cfg_t                    cfg,
  output logic [TIME_WIDTH-1:0]             refresh_period
);

  adrc_pkg::cfg_t                  cfg_r;
  logic [TIME_WIDTH-1:0]           period_r;
  logic                            wr_en;
  logic [adrc_pkg::CFG_IDX_W-1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[adrc_pkg::CFG_ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_w <= adrc_pkg::CFG_FIELD_W'(8);
      cfg_r.col_w <= adrc_pkg::CFG_FIELD_W'(8);
      cfg_r.dat_w <= adrc_pkg::CFG_FIELD_W'(8);
      period_r    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        adrc_pkg::REG_ROW_BITS:       cfg_r.row_w <= pwdata[adrc_pkg::CFG_FIELD_W-1:0];
        adrc_pkg::REG_COL_BITS:       cfg_r.col_w <= pwdata[adrc_pkg::CFG_FIELD_W-1:0];
        adrc_pkg::REG_DATA_BITS:      cfg_r.dat_w <= pwdata[adrc_pkg::CFG_FIELD_W-1:0];
        adrc_pkg::REG_REFRESH_PERIOD: period_r    <= pwdata[TIME_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      adrc_pkg::REG_ROW_BITS:       prdata = adrc_pkg::CFG_DATA_W'(cfg_r.row_w);
      adrc_pkg::REG_COL_BITS:       prdata = adrc_pkg::CFG_DATA_W'(cfg_r.col_w);
      adrc_pkg::REG_DATA_BITS:      prdata = adrc_pkg::CFG_DATA_W'(cfg_r.dat_w);
      adrc_pkg::REG_REFRESH_PERIOD: prdata = adrc_pkg::CFG_DATA_W'(period_r);
      default:                      prdata = '0;
    endcase
  end

  assign cfg            = cfg_r;
  assign refresh_period = period_r;

endmodule

/* hw/rtl/adrc_refresh_mem.sv */
module adrc_refresh_mem #(
  parameter int ROW_W  = 8,
  parameter int TIME_W = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ROW_W-1:0]  rd_row,
  input  logic [TIME_W-1:0] rd_now,
  input  logic [TIME_W-1:0] period,
  output logic              late
);

  localparam int DEPTH = 1 << ROW_W;

  logic [TIME_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [TIME_W-1:0] rdata_r;
  logic              hit_vld_r;
  logic              pend_r;
  logic [ROW_W-1:0]  row_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] last;
  logic [TIME_W:0]   deadline;

  // read on the request edge, write back the new time in the cycle after
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_row];
    end
    if (pend_r) begin
      mem[row_r] <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      vld_r  <= '0;
    end else begin
      pend_r <= rd_en;
      if (pend_r) begin
        vld_r[row_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_r     <= rd_row;
      now_r     <= rd_now;
      hit_vld_r <= vld_r[rd_row];
    end
  end

  // a row never refreshed since reset counts as refreshed at time zero
  assign last     = hit_vld_r ? rdata_r : '0;
  assign deadline = {1'b0, last} + {1'b0, period};
  assign late     = pend_r && ({1'b0, now_r} > deadline);

endmodule

/* hw/rtl/adrc_word_mem.sv */
module adrc_word_mem #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* tb/async_dram_with_refresh_check_tb.sv */
`timescale 1ns / 1ps

module async_dram_with_refresh_check_tb;

  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        ras;
    logic        cas;
    logic        we;
    logic        oe;
    logic [7:0]  addr;
    logic [7:0]  data;
    logic [47:0] now;
  } pins_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       rvalid;
    logic       drive;
    logic       err;
  } dram_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_ras_active = 1'b0;
  logic in_cas_active = 1'b0;
  logic in_we_active = 1'b0;
  logic in_oe_active = 1'b0;
  logic [7:0] in_addr_bus = '0;
  logic [7:0] in_data_bus = '0;
  logic [47:0] in_now_time = '0;
  logic out_strobe;
  logic [7:0] out_read_data;
  logic out_read_valid;
  logic out_drive_enable;
  logic out_refresh_error;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [adrc_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [adrc_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [adrc_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  // shadow of the block: configuration and pin/memory state
  logic [3:0] row_w_q = 4'd8;
  logic [3:0] col_w_q = 4'd8;
  logic [3:0] dat_w_q = 4'd8;
  logic [47:0] refresh_period_q = '0;
  logic ras_q = 1'b0;
  logic cas_q = 1'b0;
  logic error_q = 1'b0;
  logic [7:0] row_latch_q = '0;
  logic [7:0] cbr_count_q = '0;
  logic [7:0] read_hold_q = '0;
  bit [47:0] row_time [0:255];
  bit [7:0] word_mem [0:65535];
  bit word_written [0:65535];

  dram_out_t expected_outputs [$];
  int unsigned mismatches = 0;
  int unsigned sent_count = 0;
  int unsigned burst_left = 0;
  bit time_random = 1'b0;
  logic [47:0] tick_now = '0;

  async_dram_with_refresh_check dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_ras_active(in_ras_active),
    .in_cas_active(in_cas_active),
    .in_we_active(in_we_active),
    .in_oe_active(in_oe_active),
    .in_addr_bus(in_addr_bus),
    .in_data_bus(in_data_bus),
    .in_now_time(in_now_time),
    .out_strobe(out_strobe),
    .out_read_data(out_read_data),
    .out_read_valid(out_read_valid),
    .out_drive_enable(out_drive_enable),
    .out_refresh_error(out_refresh_error),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // zero or out-of-range widths fall back to the full 8 bits
  function automatic int unsigned used_width(logic [3:0] v);
    return (v == 0 || v > 8) ? 8 : v;
  endfunction

  function automatic logic [7:0] field_mask(logic [3:0] v);
    return 8'hFF >> (8 - used_width(v));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // word touched by a CAS fall in this snapshot; a RAS fall in the same
  // snapshot latches its row first
  function automatic logic [15:0] access_index(pins_t p);
    logic [7:0] row;
    row = (p.ras && !ras_q && !cas_q) ? p.addr : row_latch_q;
    row = row & field_mask(row_w_q);
    return (16'(row) << used_width(col_w_q)) | 16'(p.addr & field_mask(col_w_q));
  endfunction

  function automatic void refresh_row(logic [7:0] row, logic [47:0] now);
    if (now > row_time[row] && now - row_time[row] > refresh_period_q) error_q = 1'b1;
    row_time[row] = now;
  endfunction

  function automatic dram_out_t dram_next_outputs(pins_t p);
    dram_out_t r;
    logic [15:0] idx;
    logic [7:0] rmask;
    logic [7:0] row;
    idx = access_index(p);
    rmask = field_mask(row_w_q);
    r.drive = p.oe & p.cas & ~p.we;
    r.rvalid = 1'b0;
    if (p.ras && !ras_q) begin
      if (!cas_q) begin
        row_latch_q = p.addr & rmask;
        refresh_row(row_latch_q, p.now);
      end else begin
        // cas-before-ras: refresh the counter row
        row = cbr_count_q & rmask;
        cbr_count_q = (row + 8'd1) & rmask;
        refresh_row(row, p.now);
      end
    end
    ras_q = p.ras;
    if (p.cas && !cas_q && p.ras) begin
      if (p.we) begin
        word_mem[idx] = p.data & field_mask(dat_w_q);
        word_written[idx] = 1'b1;
      end else begin
        read_hold_q = word_mem[idx];
        r.rvalid = 1'b1;
      end
    end
    cas_q = p.cas;
    r.rdata = read_hold_q;
    r.err = error_q;
    return r;
  endfunction

  function automatic pins_t pin_snapshot(logic ras, logic cas, logic we, logic oe,
                                         logic [7:0] addr, logic [7:0] data);
    pins_t p;
    p.ras = ras;
    p.cas = cas;
    p.we = we;
    p.oe = oe;
    p.addr = addr;
    p.data = data;
    p.now = tick_now;
    if (time_random) begin
      case ($urandom_range(0, 7))
        0: p.now = '0;
        1: p.now = TIME_MAX;
        default: p.now = {16'($urandom), $urandom};
      endcase
    end
    return p;
  endfunction

  // mostly a few low addresses so reads find written words
  function automatic logic [7:0] pick_addr();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
  endfunction

  task automatic send_request(pins_t p);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    // never read a word that was not written since reset
    if (p.cas && !cas_q && p.ras && !p.we && !word_written[access_index(p)]) p.we = 1'b1;
    in_ras_active <= p.ras;
    in_cas_active <= p.cas;
    in_we_active <= p.we;
    in_oe_active <= p.oe;
    in_addr_bus <= p.addr;
    in_data_bus <= p.data;
    in_now_time <= p.now;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_outputs.push_back(dram_next_outputs(p));
    sent_count++;
  endtask

  // waits for all results, then writes every register back to back
  task automatic load_config(logic [3:0] rb, logic [3:0] cb, logic [3:0] db,
                             logic [47:0] period);
    logic [63:0] vals [4];
    logic [adrc_pkg::CFG_IDX_W-1:0] regs [4];
    vals = '{64'(rb), 64'(cb), 64'(db), 64'(period)};
    regs = '{adrc_pkg::REG_ROW_BITS, adrc_pkg::REG_COL_BITS, adrc_pkg::REG_DATA_BITS,
             adrc_pkg::REG_REFRESH_PERIOD};
    start <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {regs[i], 3'b000};
      pwdata <= vals[i];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    row_w_q = rb;
    col_w_q = cb;
    dat_w_q = db;
    refresh_period_q = period;
  endtask

  task automatic ras_refresh(logic [1:0] row, logic [47:0] t);
    tick_now = t;
    send_request(pin_snapshot(1, 0, 0, rand_bit(), {6'($urandom), row}, 8'($urandom)));
    send_request(pin_snapshot(0, 0, 0, 0, 8'($urandom), 8'($urandom)));
  endtask

  task automatic test_page_access();
    load_config(4'd8, 4'd8, 4'd8, 48'd0);
    time_random = 1'b0;
    tick_now = '0;
    send_request(pin_snapshot(1, 0, 0, 0, 8'hFF, 8'h00));
    send_request(pin_snapshot(1, 1, 1, 1, 8'hFF, 8'hFF));
    send_request(pin_snapshot(1, 0, 0, 1, 8'h00, 8'h00));
    send_request(pin_snapshot(1, 1, 0, 1, 8'hFF, 8'h00));
    send_request(pin_snapshot(1, 0, 0, 0, 8'h00, 8'hFF));
    send_request(pin_snapshot(0, 0, 0, 0, 8'h00, 8'h00));
    // both strobes fall together: row latch, then write
    send_request(pin_snapshot(1, 1, 1, 0, 8'h00, 8'hA5));
    send_request(pin_snapshot(1, 0, 1, 0, 8'h5A, 8'h00));
    send_request(pin_snapshot(1, 1, 0, 1, 8'h00, 8'hFF));
    // ras rises while cas still low, output keeps driving
    send_request(pin_snapshot(0, 1, 0, 1, 8'h00, 8'h00));
    send_request(pin_snapshot(0, 0, 0, 0, 8'h00, 8'h00));
  endtask

  task automatic test_cas_before_ras();
    load_config(4'd2, 4'd8, 4'd8, 48'd0);
    send_request(pin_snapshot(0, 1, 0, 1, 8'h33, 8'h00));
    send_request(pin_snapshot(1, 1, 0, 1, 8'hCC, 8'h00));
    send_request(pin_snapshot(0, 1, 1, 1, 8'h00, 8'h00));
    send_request(pin_snapshot(1, 1, 0, 0, 8'h00, 8'h00));
    send_request(pin_snapshot(0, 1, 0, 0, 8'h00, 8'h00));
    send_request(pin_snapshot(0, 0, 0, 0, 8'h00, 8'h00));
  endtask

  task automatic test_random_traffic(int unsigned items, logic [3:0] rb, logic [3:0] cb,
                                     logic [3:0] db);
    int unsigned target;
    int unsigned kind;
    load_config(rb, cb, db, TIME_MAX);
    time_random = 1'b1;
    target = sent_count + items;
    while (sent_count < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 8 && (ras_q || cas_q))
        send_request(pin_snapshot(0, 0, rand_bit(), rand_bit(),
                                  8'($urandom), 8'($urandom)));
      if (kind < 6) begin
        // ras cycle with one or more page-mode column requests
        send_request(pin_snapshot(1, 0, rand_bit(), rand_bit(),
                                  pick_addr(), 8'($urandom)));
        repeat ($urandom_range(1, 3)) begin
          send_request(pin_snapshot(1, 1, rand_bit(), rand_bit(),
                                    pick_addr(), 8'($urandom)));
          send_request(pin_snapshot(1, 0, rand_bit(), rand_bit(),
                                    8'($urandom), 8'($urandom)));
        end
        send_request(pin_snapshot(0, 0, rand_bit(), rand_bit(),
                                  8'($urandom), 8'($urandom)));
      end else if (kind < 8) begin
        send_request(pin_snapshot(0, 1, rand_bit(), rand_bit(),
                                  8'($urandom), 8'($urandom)));
        send_request(pin_snapshot(1, 1, rand_bit(), rand_bit(),
                                  8'($urandom), 8'($urandom)));
        send_request(pin_snapshot(0, 1, rand_bit(), rand_bit(),
                                  8'($urandom), 8'($urandom)));
        send_request(pin_snapshot(0, 0, rand_bit(), rand_bit(),
                                  8'($urandom), 8'($urandom)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_request(pin_snapshot(rand_bit(), rand_bit(), rand_bit(), rand_bit(),
                                    pick_addr(), 8'($urandom)));
      end
    end
  endtask

  // the error flag is sticky, so this runs last
  task automatic test_refresh_deadline();
    load_config(4'd2, 4'd2, 4'd8, TIME_MAX);
    time_random = 1'b0;
    tick_now = '0;
    send_request(pin_snapshot(0, 0, 0, 0, 8'h00, 8'h00));
    ras_refresh(2'd0, 48'h8000_0000_0001);
    ras_refresh(2'd1, 48'h8000_0000_0001);
    ras_refresh(2'd2, 48'h7FFF_FFFF_FFFC);
    ras_refresh(2'd3, 48'hFFFF_FFFF_FFF0);
    load_config(4'd2, 4'd2, 4'd8, 48'h20);
    // time runs backwards: a 48-bit sum of last time and period would wrap here
    ras_refresh(2'd3, 48'h11);
    ras_refresh(2'd3, 48'h31);
    load_config(4'd2, 4'd2, 4'd8, 48'h7FFF_FFFF_FFFE);
    ras_refresh(2'd0, TIME_MAX);
    ras_refresh(2'd1, TIME_MAX);
    // five ticks past the deadline
    ras_refresh(2'd2, TIME_MAX);
    time_random = 1'b1;
    send_request(pin_snapshot(0, 1, 0, 1, 8'($urandom), 8'($urandom)));
    send_request(pin_snapshot(1, 1, 0, 1, 8'($urandom), 8'($urandom)));
    send_request(pin_snapshot(0, 1, 0, 0, 8'($urandom), 8'($urandom)));
    send_request(pin_snapshot(0, 0, 0, 0, 8'($urandom), 8'($urandom)));
    load_config(4'd1, 4'd1, 4'd1, 48'd0);
    ras_refresh(2'd1, 48'd0);
    ras_refresh(2'd0, TIME_MAX);
  endtask

  always @(posedge clk) begin : check_outputs
    dram_out_t seen;
    dram_out_t want;
    if (rst_n && out_strobe) begin
      seen = {out_read_data, out_read_valid, out_drive_enable, out_refresh_error};
      if (expected_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with no request pending: %h", $time, seen);
      end else begin
        want = expected_outputs.pop_front();
        if (seen.rdata !== want.rdata || seen.rvalid !== want.rvalid ||
            seen.drive !== want.drive || seen.err !== want.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: read_data %h/%h read_valid %b/%b drive %b/%b error %b/%b (exp/got)",
                     $time, want.rdata, seen.rdata, want.rvalid, seen.rvalid,
                     want.drive, seen.drive, want.err, seen.err);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_page_access();
    test_cas_before_ras();
    test_random_traffic(150, 4'd8, 4'd8, 4'd8);
    test_random_traffic(150, 4'd1, 4'd1, 4'd1);
    test_random_traffic(120, 4'd0, 4'd0, 4'd0);
    test_random_traffic(120, 4'd15, 4'd12, 4'd9);
    test_random_traffic(120, 4'd2, 4'd3, 4'd4);
    test_random_traffic(120, 4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)),
                        4'($urandom_range(1, 8)));
    test_refresh_deadline();
    start <= 1'b0;
    for (int w = 0; w < 1000 && expected_outputs.size() != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (expected_outputs.size() != 0)
      $display("%0d results never arrived", expected_outputs.size());
    mismatches += expected_outputs.size();
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/adrc_pkg.sv
hw/rtl/adrc_cfg_regs.sv
hw/rtl/adrc_refresh_mem.sv
hw/rtl/adrc_word_mem.sv
hw/rtl/async_dram_with_refresh_check.sv
tb/async_dram_with_refresh_check_tb.sv
